FILE: rtl/core/awc_pkg.sv
package awc_pkg;

  localparam int CH_W            = 7;
  localparam int COUNT_W         = 16;
  localparam int PATTERN_MAX_DEF = 32;
  localparam int ALPHABET_DEF    = 128;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // request kinds
  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] ch;
    logic            last;
  } char_req_t;

  typedef struct packed {
    logic               window_match;
    logic [COUNT_W-1:0] match_count;
    logic               done_res;
  } result_t;

endpackage

FILE: rtl/core/awc_ram.sv
module awc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/anagram_window_counter.sv
// A text request goes through issue (enter, then leave phase) and modify/write into the
//   result queue, which offers it on res. Its two histogram read-modify-writes (entering and
//   leaving character) share the RAM's one write port, so it holds off the next request
//   until its leave phase. A pattern character makes at most one op and gives no result.
// Reset: rst (synchronous, active high) clears pointers, counts, the result queue and the
//   per-entry valid bits of the histogram; no clearing pass, the block takes requests at once.
module anagram_window_counter
  import awc_pkg::*;
#(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  char_req_t char_data,
  output logic      res_valid,
  input  logic      res_stall,
  output result_t   res_data
);

  // Widths. Histogram entries span -PATTERN_MAX..PATTERN_MAX, the mismatch
  // total (sum of magnitudes) at most twice that.
  localparam int KW = $clog2(ALPHABET_SIZE);
  localparam int BW = $clog2(PATTERN_MAX + 1) + 1;
  localparam int MW = $clog2(2 * PATTERN_MAX + 1);
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int DW = LW + 1;

  // result queue: three slots cover two requests in flight plus one waiting
  localparam int QDEPTH = 3;
  localparam int QW     = 2;

  // issue phases of a text request
  localparam logic PH_ENTER = 1'b0;
  localparam logic PH_LEAVE = 1'b1;

  // character code -> histogram index (code modulo alphabet size)
  logic [KW-1:0] idx_tab [2**CH_W];
  for (genvar gi = 0; gi < 2**CH_W; gi++) begin : g_idx
    assign idx_tab[gi] = KW'(gi % ALPHABET_SIZE);
  end

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  logic [PW-1:0] ring_ptr;
  logic [LW-1:0] pat_len;
  logic [LW-1:0] win_fill;
  logic [MW-1:0] mismatch;
  logic [COUNT_W-1:0] run_count;
  logic [ALPHABET_SIZE-1:0] hist_vld;

  // issue stage: holds the request while its histogram ops go out
  logic          iss_v;
  logic          iss_mode;
  logic [KW-1:0] iss_idx;
  logic          iss_last;
  logic          iss_phase;
  logic          iss_full_pre;   // window was full before this character
  logic          iss_full_post;  // window is full after it

  // modify/write stage
  logic          m_wr;
  logic          m_up;
  logic          m_res;
  logic          m_full;
  logic          m_last;
  logic [KW-1:0] m_addr;

  // write forwarding (RAM read was issued in the cycle of this write)
  logic          fwd_v;
  logic [KW-1:0] fwd_addr;
  logic [BW-1:0] fwd_data;

  // result queue and outstanding-result count
  result_t       rq [QDEPTH];
  logic [QW-1:0] rq_wr;
  logic [QW-1:0] rq_rd;
  logic [QW-1:0] rq_cnt;
  logic [QW-1:0] pending;

  // ---------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------
  logic iss_finish;
  logic take;
  logic take_text;
  logic pop;
  logic push;

  assign iss_finish = iss_v && (iss_mode == MODE_PATTERN || iss_phase == PH_LEAVE);
  // pending counts every text request taken and not yet delivered, so the
  // queue never overflows whatever res_stall does
  assign char_stall = (iss_v && !iss_finish) || (pending == QW'(QDEPTH));
  assign take       = char_valid && !char_stall;
  assign take_text  = take && char_data.mode == MODE_TEXT;
  assign res_valid  = rq_cnt != '0;
  assign res_data   = rq[rq_rd];
  assign pop        = res_valid && !res_stall;

  // ---------------------------------------------------------------
  // Window ring: index of the character leaving the window
  // ---------------------------------------------------------------
  logic [DW-1:0] back_raw;
  logic [DW-1:0] back_pos;
  logic [KW-1:0] ring_q;
  logic          ring_we;
  logic          len_nz;

  assign len_nz   = pat_len != '0;
  assign back_raw = DW'(ring_ptr) + DW'(PATTERN_MAX) - DW'(pat_len);
  assign back_pos = (back_raw >= DW'(PATTERN_MAX)) ? back_raw - DW'(PATTERN_MAX) : back_raw;
  // the ring read goes out in the enter phase, its data is used in the leave phase;
  // with a full-length pattern the read-first RAM yields the old entry
  assign ring_we  = iss_v && iss_mode == MODE_TEXT && iss_phase == PH_ENTER && len_nz;

  awc_ram #(.WIDTH(KW), .DEPTH(PATTERN_MAX)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_ptr),
    .wdata (iss_idx),
    .raddr (back_pos[PW-1:0]),
    .rdata (ring_q)
  );

  // ---------------------------------------------------------------
  // Issue: one histogram op per cycle
  // ---------------------------------------------------------------
  logic          op_wr;
  logic          op_up;
  logic          op_res;
  logic [KW-1:0] op_addr;
  logic          fill_short;
  logic [LW-1:0] fill_next;

  assign fill_short = win_fill < pat_len;
  assign fill_next  = (len_nz && fill_short) ? win_fill + LW'(1) : win_fill;

  always_comb begin
    op_wr   = 1'b0;
    op_up   = 1'b0;
    op_res  = 1'b0;
    op_addr = iss_idx;
    if (iss_v) begin
      if (iss_mode == MODE_PATTERN) begin
        op_wr = pat_len < LW'(PATTERN_MAX);
      end else if (iss_phase == PH_ENTER) begin
        op_wr = len_nz;
        op_up = 1'b1;
      end else begin
        op_wr   = iss_full_pre;
        op_addr = ring_q;
        op_res  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_v    <= 1'b0;
      ring_ptr <= '0;
      pat_len  <= '0;
      win_fill <= '0;
    end else begin
      if (take) begin
        iss_v <= 1'b1;
      end else if (iss_finish) begin
        iss_v <= 1'b0;
      end
      if (iss_v) begin
        if (iss_mode == MODE_PATTERN) begin
          if (pat_len < LW'(PATTERN_MAX)) begin
            pat_len <= pat_len + LW'(1);
          end
        end else if (iss_phase == PH_ENTER) begin
          win_fill <= fill_next;
          if (len_nz) begin
            ring_ptr <= (ring_ptr == PW'(PATTERN_MAX - 1)) ? '0 : ring_ptr + PW'(1);
          end
        end else if (iss_last) begin
          ring_ptr <= '0;
          pat_len  <= '0;
          win_fill <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      iss_mode  <= char_data.mode;
      iss_idx   <= idx_tab[char_data.ch];
      iss_last  <= char_data.last;
      iss_phase <= PH_ENTER;
    end else if (iss_v && iss_phase == PH_ENTER) begin
      iss_phase <= PH_LEAVE;
    end
    if (iss_v && iss_phase == PH_ENTER) begin
      iss_full_pre  <= len_nz && !fill_short;
      iss_full_post <= len_nz && fill_next == pat_len;
    end
  end

  // ---------------------------------------------------------------
  // Histogram RAM and modify/write stage
  // ---------------------------------------------------------------
  logic [BW-1:0]        hist_q;
  logic signed [BW-1:0] bal_cur;
  logic signed [BW-1:0] bal_new;
  logic [MW-1:0]        mis_op;
  logic                 hit;
  logic [COUNT_W-1:0]   count_op;
  logic                 clear;

  awc_ram #(.WIDTH(BW), .DEPTH(ALPHABET_SIZE)) u_hist (
    .clk   (clk),
    .we    (m_wr),
    .waddr (m_addr),
    .wdata (bal_new),
    .raddr (op_addr),
    .rdata (hist_q)
  );

  always_comb begin
    if (fwd_v && fwd_addr == m_addr) begin
      bal_cur = $signed(fwd_data);
    end else if (hist_vld[m_addr]) begin
      bal_cur = $signed(hist_q);
    end else begin
      bal_cur = '0;
    end
    bal_new = m_up ? bal_cur + BW'(1) : bal_cur - BW'(1);
    mis_op  = mismatch;
    if (m_wr) begin
      // moving toward zero shrinks the total, away from zero grows it
      if (m_up ? bal_cur[BW-1] : (!bal_cur[BW-1] && bal_cur != '0)) begin
        mis_op = mismatch - MW'(1);
      end else begin
        mis_op = mismatch + MW'(1);
      end
    end
    hit      = m_res && m_full && mis_op == '0;
    count_op = (hit && run_count != COUNT_MAX) ? run_count + COUNT_W'(1) : run_count;
  end

  assign clear = m_res && m_last;
  assign push  = m_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_wr      <= 1'b0;
      m_res     <= 1'b0;
      fwd_v     <= 1'b0;
      mismatch  <= '0;
      run_count <= '0;
      hist_vld  <= '0;
    end else begin
      m_wr  <= op_wr;
      m_res <= op_res;
      fwd_v <= m_wr && !clear;
      if (clear) begin
        mismatch  <= '0;
        run_count <= '0;
        hist_vld  <= '0;
      end else begin
        mismatch <= mis_op;
        if (m_res) begin
          run_count <= count_op;
        end
        if (m_wr) begin
          hist_vld[m_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    m_up     <= op_up;
    m_addr   <= op_addr;
    m_full   <= iss_full_post;
    m_last   <= iss_last;
    fwd_addr <= m_addr;
    fwd_data <= bal_new;
  end

  // ---------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr   <= '0;
      rq_rd   <= '0;
      rq_cnt  <= '0;
      pending <= '0;
    end else begin
      if (push) begin
        rq_wr <= (rq_wr == QW'(QDEPTH - 1)) ? '0 : rq_wr + QW'(1);
      end
      if (pop) begin
        rq_rd <= (rq_rd == QW'(QDEPTH - 1)) ? '0 : rq_rd + QW'(1);
      end
      rq_cnt  <= rq_cnt + QW'(push) - QW'(pop);
      pending <= pending + QW'(take_text) - QW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rq[rq_wr] <= '{window_match: hit, match_count: count_op, done_res: m_last};
    end
  end

endmodule

FILE: rtl/core/awc_checker.sv
module awc_checker
  import awc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      char_valid,
  input logic      char_stall,
  input char_req_t char_data,
  input logic      res_valid,
  input logic      res_stall,
  input result_t   res_data
);

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // a matching window is always counted
  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.window_match |-> res_data.match_count != '0)
    else $error("match reported with zero count");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered after reset");

  // a taken text request stalls the next request while its histogram ops go out
  a_text_two_cycles: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && char_data.mode == MODE_TEXT |=> char_stall)
    else $error("text request followed without a gap");

endmodule

bind anagram_window_counter awc_checker u_awc_checker (.*);
